@@ rtl/sliding_window_average_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Sliding window average unit: assertion macros
// Concurrent checks sampled on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_AVERAGE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SWA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SWA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// Shared widths, command format and back-end states of the window averager.
// ----------------------------------------------------------------------------
`default_nettype none

package swa_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int SAMPLE_W     = 32;
  localparam int LEN_W        = $clog2(MAX_WINDOW + 1);
  localparam int POS_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W        = SAMPLE_W + POS_W;
  localparam int REM_W        = LEN_W - 1 > 0 ? LEN_W - 1 : 1;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
  localparam int LEN_RESET    = 8;

  // Control from the register block to the front end.
  typedef struct packed {
    logic             restart;
    logic [LEN_W-1:0] len;
  } ctrl_t;

  // One classified sample, front end to back end.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [POS_W-1:0]    pos;
    logic                pass;   // window still filling: raw sample out
    logic                first;  // first sample after a restart
    logic [LEN_W-1:0]    len;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_UPDATE,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_t;

  // Clamp a written length into 1..MAX_WINDOW.
  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (v > LEN_W'(MAX_WINDOW)) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/swa_front.sv @@
// ----------------------------------------------------------------------------
// swa_front
// Accepts samples, tracks ring position and fill count, tags each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire swa_pkg::ctrl_t                     ctrl,
  input  wire logic                               push,
  input  wire logic [swa_pkg::SAMPLE_W-1:0]       in_sample,
  output      logic                               full,
  input  wire logic                               q_full,
  output      logic                               q_push,
  output      swa_pkg::cmd_t                      q_cmd
);

  logic [swa_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [swa_pkg::LEN_W-1:0] fill_r, fill_nxt;
  logic [swa_pkg::LEN_W-1:0] pos_inc;
  logic                      pass;

  assign full    = q_full;
  assign q_push  = push && !q_full;
  assign pass    = fill_r < ctrl.len;
  assign pos_inc = swa_pkg::LEN_W'(pos_r) + swa_pkg::LEN_W'(1);

  assign q_cmd.sample = in_sample;
  assign q_cmd.pos    = pos_r;
  assign q_cmd.pass   = pass;
  assign q_cmd.first  = (fill_r == '0);
  assign q_cmd.len    = ctrl.len;

  always_comb begin
    pos_nxt  = pos_r;
    fill_nxt = fill_r;
    if (ctrl.restart) begin
      pos_nxt  = '0;
      fill_nxt = '0;
    end else if (q_push) begin
      // advance and wrap at the window length
      pos_nxt = (pos_inc >= ctrl.len) ? '0 : pos_inc[swa_pkg::POS_W-1:0];
      if (pass) begin
        fill_nxt = fill_r + swa_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swa_cmd_q.sv @@
// ----------------------------------------------------------------------------
// swa_cmd_q
// Two-entry queue of tagged samples between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_cmd_q (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_push,
  input  wire swa_pkg::cmd_t q_cmd,
  output      logic          q_full,
  input  wire logic          q_pop,
  output      logic          q_empty,
  output      swa_pkg::cmd_t q_head
);

  swa_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_full  = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_head  = entry_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= q_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/swa_back.sv @@
// ----------------------------------------------------------------------------
// swa_back
// Window memory, running sum and serial divider; holds one result register.
// ----------------------------------------------------------------------------
`default_nettype none

module swa_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_empty,
  input  wire swa_pkg::cmd_t                 q_head,
  output      logic                          q_pop,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic [swa_pkg::SAMPLE_W-1:0]  out_filtered,
  output      logic                          out_is_average
);

  localparam int SW = swa_pkg::SAMPLE_W;
  localparam int UW = swa_pkg::SUM_W;
  localparam int RW = swa_pkg::REM_W;
  localparam int LW = swa_pkg::LEN_W;
  localparam int CW = swa_pkg::DIV_CNT_W;

  swa_pkg::back_state_t state_r, state_nxt;

  logic [SW-1:0] win_mem [swa_pkg::MAX_WINDOW];

  swa_pkg::cmd_t cmd_r, cmd_nxt;
  logic [SW-1:0] old_r;
  logic [UW-1:0] sum_r, sum_nxt;
  logic [UW-1:0] quot_r, quot_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] res_r, res_nxt;
  logic          avg_r, avg_nxt;
  logic [LW-1:0] trial;

  assign empty          = (state_r != swa_pkg::BK_OUTPUT);
  assign out_filtered   = res_r;
  assign out_is_average = avg_r;
  assign trial          = {rem_r, quot_r[UW-1]};

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    sum_nxt   = sum_r;
    quot_nxt  = quot_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    avg_nxt   = avg_r;
    q_pop     = 1'b0;
    unique case (state_r)
      swa_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          cmd_nxt   = q_head;
          state_nxt = swa_pkg::BK_READ;
        end
      end
      swa_pkg::BK_READ: begin
        state_nxt = swa_pkg::BK_UPDATE;
      end
      swa_pkg::BK_UPDATE: begin
        if (cmd_r.first) begin
          sum_nxt = UW'(cmd_r.sample);
        end else if (cmd_r.pass) begin
          sum_nxt = sum_r + UW'(cmd_r.sample);
        end else begin
          // drop the overwritten entry, add the new one
          sum_nxt = sum_r - UW'(old_r) + UW'(cmd_r.sample);
        end
        if (cmd_r.pass) begin
          res_nxt   = cmd_r.sample;
          avg_nxt   = 1'b0;
          state_nxt = swa_pkg::BK_OUTPUT;
        end else begin
          quot_nxt  = sum_nxt;
          rem_nxt   = '0;
          cnt_nxt   = CW'(UW);
          state_nxt = swa_pkg::BK_DIVIDE;
        end
      end
      swa_pkg::BK_DIVIDE: begin
        // one restoring step per cycle, MSB first
        if (trial >= cmd_r.len) begin
          rem_nxt  = RW'(trial - cmd_r.len);
          quot_nxt = {quot_r[UW-2:0], 1'b1};
        end else begin
          rem_nxt  = trial[RW-1:0];
          quot_nxt = {quot_r[UW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          res_nxt   = quot_nxt[SW-1:0];
          avg_nxt   = 1'b1;
          state_nxt = swa_pkg::BK_OUTPUT;
        end
      end
      swa_pkg::BK_OUTPUT: begin
        if (pop) begin
          state_nxt = swa_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = swa_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swa_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    sum_r  <= sum_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
    avg_r  <= avg_nxt;
  end

  // Read the outgoing entry, then overwrite it with the new sample.
  always_ff @(posedge clk) begin
    if (state_r == swa_pkg::BK_READ) begin
      old_r <= win_mem[cmd_r.pos];
    end
    if (state_r == swa_pkg::BK_UPDATE) begin
      win_mem[cmd_r.pos] <= cmd_r.sample;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sliding_window_average_unit.sv @@
// Sliding window average unit.
// Each sample passes the queue, then the back end's read and update states; once the window
// is full it also passes the 36-step serial divider. The back end takes the next sample only
// after its result is popped.
// A two-entry queue lets the front end take samples while a result waits.
// Reset (rst_n low, synchronous): window length 8, position and fill cleared.
`default_nettype none

`include "sliding_window_average_unit_assert.svh"

module sliding_window_average_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic [swa_pkg::SAMPLE_W-1:0]  in_sample,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic [swa_pkg::SAMPLE_W-1:0]  out_filtered,
  output      logic                          out_is_average,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [1:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  localparam int LW = swa_pkg::LEN_W;

  logic [LW-1:0]  len_r, len_nxt;
  logic           cfg_wr;
  logic           len_ok;
  swa_pkg::ctrl_t ctrl;
  logic           q_push, q_full, q_pop, q_empty;
  swa_pkg::cmd_t  q_cmd, q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = 32'(len_r) | 32'(paddr & 2'b00);
  assign len_nxt = cfg_wr ? swa_pkg::clamp_len(pwdata[LW-1:0]) : len_r;
  assign len_ok  = (len_r != '0) && (len_r <= LW'(swa_pkg::MAX_WINDOW));

  assign ctrl.restart = cfg_wr;
  assign ctrl.len     = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= swa_pkg::clamp_len(LW'(swa_pkg::LEN_RESET));
    end else begin
      len_r <= len_nxt;
    end
  end

  swa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .push      (push),
    .in_sample (in_sample),
    .full      (full),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  swa_cmd_q u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_cmd   (q_cmd),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_head  (q_head)
  );

  swa_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .out_filtered   (out_filtered),
    .out_is_average (out_is_average)
  );

  `SWA_ASSERT_NXT(a_len_range, cfg_wr, len_ok, "window length out of range after write")
  `SWA_ASSERT_IMP(a_pos_in_window, q_push, q_cmd.pos < q_cmd.len, "position past window length")
  `SWA_ASSERT_IMP(a_first_is_pass, q_push && q_cmd.first, q_cmd.pass, "first sample not fill")

endmodule

`default_nettype wire
